FILE: sv/dtw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_pkg
// Shared constants, types and a helper function for the tuning word loader.
// ---------------------------------------------------------------------------
package dtw_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned DigitCount = 8;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned RemW       = 27;   // holds any value below 10^8
  localparam int unsigned LoadBits   = 40;
  localparam int unsigned IdxW       = 6;

  localparam logic [WordW-1:0] WeightReset = 32'd343597383;
  localparam logic [WordW-1:0] TenE8       = 32'd100000000;
  localparam logic [IdxW-1:0]  LastIdx     = 6'(LoadBits - 1);
  localparam logic [IdxW-1:0]  WordBitsIdx = 6'(WordW);

  // floor(f / 10^8) = ((f >> 8) * ModMagic) >> 43 for every 32-bit f
  localparam logic [24:0] ModMagic = 25'd22517999;
  localparam logic [WordW-1:0] Div10Magic = 32'hCCCCCCCD;

  typedef logic [DigitCount-1:0][DigitW-1:0] dig_vec_t;
  typedef logic [DigitCount-1:0][WordW-1:0]  wt_vec_t;

  // exact floor(x / 10) for any 32-bit x
  function automatic logic [WordW-1:0] div10(input logic [WordW-1:0] x);
    logic [63:0] p;
    p = {32'b0, x} * {32'b0, Div10Magic};
    return {3'b0, p[63:35]};
  endfunction

endpackage

FILE: sv/dds_tuning_word_serial_loader.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_tuning_word_serial_loader
// Converts a frequency in hertz into a DDS tuning word and loads it serially.
// The one-bit-per-cycle serializer sends 40 bits per item and takes a new
// word directly after the last bit of the one before; the 15-stage compute
// pipeline takes a start beat in any cycle that busy is low. The receiver
// cannot stall.
// Reset empties the pipeline and sets the weight to 343597383.
// ---------------------------------------------------------------------------
module dds_tuning_word_serial_loader (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [dtw_pkg::WordW-1:0] frequency_hz_i,
  input  logic                      top_digit_weight_we_i,
  input  logic [dtw_pkg::WordW-1:0] top_digit_weight_i,
  output logic                      valid_o,
  output logic                      serial_data_o,
  output logic [dtw_pkg::IdxW-1:0]  bit_index_o,
  output logic                      last_o,
  output logic [dtw_pkg::WordW-1:0] tuning_word_o
);
  import dtw_pkg::*;

  logic [WordW-1:0] top_weight_q;
  logic             adv;
  logic             dig_vld;
  dig_vec_t         dig;
  wt_vec_t          wt;
  logic             sum_vld;
  logic [WordW-1:0] sum_word;
  logic             ser_take;

  // weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_weight_q <= WeightReset;
    end else if (top_digit_weight_we_i) begin
      top_weight_q <= top_digit_weight_i;
    end
  end

  // the whole pipeline holds while a finished word waits for the serializer
  assign adv  = !sum_vld || ser_take;
  assign busy = !adv;

  dtw_digits u_digits (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (start),
    .freq_i   (frequency_hz_i),
    .weight_i (top_weight_q),
    .vld_o    (dig_vld),
    .dig_o    (dig),
    .wt_o     (wt)
  );

  dtw_sum u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (dig_vld),
    .dig_i  (dig),
    .wt_i   (wt),
    .vld_o  (sum_vld),
    .word_o (sum_word)
  );

  dtw_serializer u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (sum_vld),
    .word_i        (sum_word),
    .take_o        (ser_take),
    .valid_o       (valid_o),
    .serial_data_o (serial_data_o),
    .bit_index_o   (bit_index_o),
    .last_o        (last_o),
    .tuning_word_o (tuning_word_o)
  );

endmodule

FILE: sv/dtw_digits.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_digits
// Input register, mod 10^8 reduction and the eight digit / weight stages.
// ---------------------------------------------------------------------------
module dtw_digits (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       vld_i,
  input  logic [dtw_pkg::WordW-1:0]  freq_i,
  input  logic [dtw_pkg::WordW-1:0]  weight_i,
  output logic                       vld_o,
  output dtw_pkg::dig_vec_t          dig_o,
  output dtw_pkg::wt_vec_t           wt_o
);
  import dtw_pkg::*;

  // input stage
  logic             a_vld_q;
  logic [WordW-1:0] a_f_q, a_w_q;
  // quotient by 10^8 stage
  logic             b_vld_q;
  logic [5:0]       b_q_q, b_q_d;
  logic [WordW-1:0] b_f_q, b_w_q;
  // digit stages, index 0 holds the reduced frequency
  logic             vld_q [DigitCount+1];
  logic [RemW-1:0]  x_q   [DigitCount];
  logic [RemW-1:0]  x_d   [DigitCount];
  dig_vec_t         dg_q  [DigitCount+1];
  dig_vec_t         dg_d  [DigitCount+1];
  wt_vec_t          wt_q  [DigitCount+1];
  wt_vec_t          wt_d  [DigitCount+1];

  logic [48:0]      mod_prod;
  logic [WordW-1:0] rem_full;

  // quotient by 10^8 through a reciprocal multiply
  always_comb begin
    mod_prod = {25'b0, a_f_q[WordW-1:8]} * {24'b0, ModMagic};
    b_q_d    = mod_prod[48:43];
  end

  // remainder, below 10^8
  assign rem_full = b_f_q - ({26'b0, b_q_q} * TenE8);

  // one divide by ten per stage for the digits, and for the weights in all stages but the last
  always_comb begin
    logic [WordW-1:0] xw;
    logic [WordW-1:0] qq;
    logic [WordW-1:0] dig;
    dg_d[0] = '0;
    wt_d[0] = '0;
    x_d[0]  = rem_full[RemW-1:0];
    wt_d[0][0] = b_w_q;
    for (int s = 1; s <= DigitCount; s++) begin
      xw  = {5'b0, x_q[s-1]};
      qq  = div10(xw);
      dig = xw - ((qq << 3) + (qq << 1));
      if (s < DigitCount) begin
        x_d[s] = qq[RemW-1:0];
      end
      dg_d[s] = dg_q[s-1];
      dg_d[s][DigitCount-s] = dig[DigitW-1:0];
      wt_d[s] = wt_q[s-1];
      if (s < DigitCount) begin
        wt_d[s][s] = div10(wt_q[s-1][s-1]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      for (int s = 0; s <= DigitCount; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      a_vld_q  <= vld_i;
      b_vld_q  <= a_vld_q;
      vld_q[0] <= b_vld_q;
      for (int s = 1; s <= DigitCount; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_f_q <= freq_i;
      a_w_q <= weight_i;
      b_q_q <= b_q_d;
      b_f_q <= a_f_q;
      b_w_q <= a_w_q;
      for (int s = 0; s < DigitCount; s++) x_q[s] <= x_d[s];
      for (int s = 0; s <= DigitCount; s++) begin
        dg_q[s] <= dg_d[s];
        wt_q[s] <= wt_d[s];
      end
    end
  end

  assign vld_o = vld_q[DigitCount];
  assign dig_o = dg_q[DigitCount];
  assign wt_o  = wt_q[DigitCount];

endmodule

FILE: sv/dtw_sum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_sum
// Digit by weight products and a registered adder tree, modulo 2^32.
// ---------------------------------------------------------------------------
module dtw_sum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  dtw_pkg::dig_vec_t         dig_i,
  input  dtw_pkg::wt_vec_t          wt_i,
  output logic                      vld_o,
  output logic [dtw_pkg::WordW-1:0] word_o
);
  import dtw_pkg::*;

  logic             p_vld_q, t1_vld_q, t2_vld_q, t3_vld_q;
  logic [WordW-1:0] prod_q [DigitCount];
  logic [WordW-1:0] t1_q   [DigitCount/2];
  logic [WordW-1:0] t2_q   [DigitCount/4];
  logic [WordW-1:0] t3_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
      t3_vld_q <= 1'b0;
    end else if (adv_i) begin
      p_vld_q  <= vld_i;
      t1_vld_q <= p_vld_q;
      t2_vld_q <= t1_vld_q;
      t3_vld_q <= t2_vld_q;
    end
  end

  // products, then three levels of adds
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < DigitCount; i++) begin
        prod_q[i] <= wt_i[i] * {28'b0, dig_i[i]};
      end
      for (int i = 0; i < DigitCount/2; i++) begin
        t1_q[i] <= prod_q[2*i] + prod_q[2*i+1];
      end
      for (int i = 0; i < DigitCount/4; i++) begin
        t2_q[i] <= t1_q[2*i] + t1_q[2*i+1];
      end
      t3_q <= t2_q[0] + t2_q[1];
    end
  end

  assign vld_o  = t3_vld_q;
  assign word_o = t3_q;

endmodule

FILE: sv/dtw_serializer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtw_serializer
// Sends each tuning word as 40 bits, LSB first, the last 8 bits zero.
// ---------------------------------------------------------------------------
module dtw_serializer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [dtw_pkg::WordW-1:0] word_i,
  output logic                      take_o,
  output logic                      valid_o,
  output logic                      serial_data_o,
  output logic [dtw_pkg::IdxW-1:0]  bit_index_o,
  output logic                      last_o,
  output logic [dtw_pkg::WordW-1:0] tuning_word_o
);
  import dtw_pkg::*;

  logic             active_q;
  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] word_q;
  logic             load;

  // a new word may follow directly after the last bit of the current one
  assign take_o = !active_q || (idx_q == LastIdx);
  assign load   = vld_i && take_o;

  // bit counter and beat marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      idx_q    <= '0;
    end else if (active_q) begin
      if (idx_q == LastIdx) begin
        active_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 6'd1;
      end
    end
  end

  // word holding register
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_i;
    end
  end

  assign valid_o       = active_q;
  assign serial_data_o = (idx_q < WordBitsIdx) ? word_q[idx_q[4:0]] : 1'b0;
  assign bit_index_o   = idx_q;
  assign last_o        = (idx_q == LastIdx);
  assign tuning_word_o = word_q;

endmodule

FILE: dv/dds_tuning_word_serial_loader_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_tuning_word_serial_loader_test
// Drives frequencies into the tuning word loader under several weight
// settings and checks every serial beat against a local tuning word model.
// ---------------------------------------------------------------------------
module dds_tuning_word_serial_loader_test;

  localparam int unsigned WordW = dtw_pkg::WordW;
  localparam int unsigned IdxW  = dtw_pkg::IdxW;

  // one serial beat of a load
  typedef struct packed {
    logic            data;
    logic [IdxW-1:0] idx;
    logic            last;
    logic [WordW-1:0] word;
  } load_beat_t;

  // tracks the weight, predicts tuning words and holds the beats still due
  class tuning_load_tracker;
    logic [WordW-1:0] weight;
    load_beat_t       due_beats[$];
    int unsigned      errors;
    int unsigned      loads_noted;
    int unsigned      beats_seen;

    function new();
      weight      = dtw_pkg::WeightReset;
      errors      = 0;
      loads_noted = 0;
      beats_seen  = 0;
    endfunction

    // low eight decimal digits, each scaled by a weight that drops tenfold
    function logic [WordW-1:0] tuning_word_for(logic [WordW-1:0] freq);
      logic [WordW-1:0] rem;
      logic [WordW-1:0] w;
      logic [WordW-1:0] acc;
      logic [WordW-1:0] digit [dtw_pkg::DigitCount];
      int i;
      rem = freq % 32'd100000000;
      w   = weight;
      acc = '0;
      for (i = dtw_pkg::DigitCount - 1; i >= 0; i--) begin
        digit[i] = rem % 32'd10;
        rem      = rem / 32'd10;
      end
      for (i = 0; i < dtw_pkg::DigitCount; i++) begin
        acc = acc + w * digit[i];
        w   = w / 32'd10;
      end
      return acc;
    endfunction

    function void note_frequency(logic [WordW-1:0] freq);
      logic [WordW-1:0] word;
      load_beat_t b;
      word = tuning_word_for(freq);
      for (int k = 0; k < dtw_pkg::LoadBits; k++) begin
        b.data = (k < WordW) ? word[k] : 1'b0;
        b.idx  = IdxW'(k);
        b.last = (k == dtw_pkg::LoadBits - 1);
        b.word = word;
        due_beats.push_back(b);
      end
      loads_noted++;
    endfunction

    task report(string msg);
      if (errors < 30) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_beat(logic data, logic [IdxW-1:0] idx, logic last, logic [WordW-1:0] word);
      load_beat_t e;
      beats_seen++;
      if (due_beats.size() == 0) begin
        report($sformatf("unexpected beat idx=%0d word=%h", idx, word));
        return;
      end
      e = due_beats.pop_front();
      if (data !== e.data)
        report($sformatf("serial_data idx=%0d got %b exp %b", e.idx, data, e.data));
      if (idx !== e.idx)
        report($sformatf("bit_index got %0d exp %0d", idx, e.idx));
      if (last !== e.last)
        report($sformatf("last idx=%0d got %b exp %b", e.idx, last, e.last));
      if (word !== e.word)
        report($sformatf("tuning_word idx=%0d got %h exp %h", e.idx, word, e.word));
    endtask

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [WordW-1:0] frequency_hz_i;
  logic             top_digit_weight_we_i;
  logic [WordW-1:0] top_digit_weight_i;
  logic             valid_o;
  logic             serial_data_o;
  logic [IdxW-1:0]  bit_index_o;
  logic             last_o;
  logic [WordW-1:0] tuning_word_o;

  tuning_load_tracker board;
  bit                 calm;
  int unsigned        weight_writes;

  dds_tuning_word_serial_loader dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .frequency_hz_i        (frequency_hz_i),
    .top_digit_weight_we_i (top_digit_weight_we_i),
    .top_digit_weight_i    (top_digit_weight_i),
    .valid_o               (valid_o),
    .serial_data_o         (serial_data_o),
    .bit_index_o           (bit_index_o),
    .last_o                (last_o),
    .tuning_word_o         (tuning_word_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      board.check_beat(serial_data_o, bit_index_o, last_o, tuning_word_o);
  end

  // one frequency beat, then an occasional gap
  task automatic send_frequency(input logic [WordW-1:0] freq);
    start          = 1'b1;
    frequency_hz_i = freq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_frequency(freq);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 6) begin
      start          = 1'b0;
      frequency_hz_i = $urandom;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // wait until every due beat has come out
  task automatic drain_loads();
    start = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // weight write, only while nothing is in flight
  task automatic write_weight(input logic [WordW-1:0] w);
    drain_loads();
    top_digit_weight_we_i = 1'b1;
    top_digit_weight_i    = w;
    @(negedge clk_i);
    top_digit_weight_we_i = 1'b0;
    board.weight          = w;
    weight_writes++;
  endtask

  // random frequency: full range, in-range, digit patterns or small values
  function automatic logic [WordW-1:0] pick_frequency();
    int unsigned sel;
    logic [WordW-1:0] f;
    sel = $urandom_range(0, 99);
    if (sel < 35) return $urandom;
    if (sel < 65) return $urandom_range(0, 99999999);
    if (sel < 85) begin
      f = '0;
      for (int i = 0; i < dtw_pkg::DigitCount; i++) begin
        case ($urandom_range(0, 2))
          0: f = f * 10;
          1: f = f * 10 + 9;
          default: f = f * 10 + $urandom_range(0, 9);
        endcase
      end
      return f + 32'd100000000 * $urandom_range(0, 41);
    end
    return $urandom_range(0, 9999);
  endfunction

  // stimulus
  initial begin
    logic [WordW-1:0] directed [18];
    logic [WordW-1:0] weights [8];
    directed = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99999999, 32'd100000000, 32'd100000001,
      32'hFFFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'd12345678,
      32'd10000000, 32'd90000000, 32'd7000000, 32'd14074000, 32'd199999999,
      32'd4294967200
    };
    weights = '{
      32'd0, 32'hFFFFFFFF, 32'd1, 32'd12345, 32'd429496729, 32'h0, 32'h0,
      dtw_pkg::WeightReset
    };
    board                 = new();
    calm                  = 1'b0;
    weight_writes         = 0;
    rst_ni                = 1'b0;
    start                 = 1'b0;
    frequency_hz_i        = '0;
    top_digit_weight_we_i = 1'b0;
    top_digit_weight_i    = '0;
    weights[5]            = $urandom;
    weights[6]            = $urandom;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed pass at the reset weight
    foreach (directed[i]) send_frequency(directed[i]);

    // random passes, one per weight setting
    foreach (weights[p]) begin
      write_weight(weights[p]);
      calm = (p == 3);
      if (p == 1) begin
        send_frequency(32'hFFFFFFFF);
        send_frequency(32'd99999999);
      end
      repeat (27) send_frequency(pick_frequency());
    end
    calm = 1'b0;

    // let the last load finish and watch for stray beats
    drain_loads();
    repeat (60) @(negedge clk_i);

    $display("covered %0d loads, %0d serial beats, %0d weight writes",
             board.loads_noted, board.beats_seen, weight_writes);
    $display("mismatches: %0d, beats still due: %0d", board.errors, board.pending());
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout waiting on the loader");
    $display("FAILURE");
    $finish;
  end

endmodule
